// ===== rtl/ppcb_pkg.sv =====
// ============================================================================
// ppcb_pkg
// Shared widths, codes and controller/datapath interface types for the
// per-peer concurrency budget unit.
// ============================================================================
package ppcb_pkg;

    localparam int KEY_W      = 256;
    localparam int WORD_W     = 64;
    localparam int CNT_W      = 16;
    localparam int PEERS_W    = 5;
    localparam int SIZE_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK           = 3'd0;
    localparam status_t ST_BAD_CONFIG   = 3'd1;
    localparam status_t ST_REQUEST_BIG  = 3'd2;
    localparam status_t ST_RESPONSE_BIG = 3'd3;
    localparam status_t ST_TIMEOUT_BAD  = 3'd4;
    localparam status_t ST_CONCURRENCY  = 3'd5;
    localparam status_t ST_PEER_LIMIT   = 3'd6;
    localparam status_t ST_NOT_HELD     = 3'd7;

    localparam logic KIND_ACQUIRE = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_CONCURRENT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_PENDING_PEERS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_PER_PEER       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_REQUEST_BYTES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_RESPONSE_BYTES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TIMEOUT_MS     = 3'd5;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic check;       // latch the pre-check status
        logic scan_start;  // clear the slot scan
        logic scan_run;    // advance the slot scan
        logic commit;      // apply the decision to the slot table
        logic out_load;    // move the result into the output register
    } ppcb_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic pre_fail;    // a pre-check rejected the transaction
        logic scan_done;   // slot scan finished (hit or all slots seen)
    } ppcb_sts_t;

endpackage

// ===== rtl/ppcb_ctrl.sv =====
// ============================================================================
// ppcb_ctrl
// Sequencer: capture, pre-check, slot scan, commit, result hand-off.
// ============================================================================
module ppcb_ctrl
    import ppcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output ppcb_cmd_t cmd,
    input  ppcb_sts_t sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_COMMIT,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (sts.pre_fail)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/ppcb_datapath.sv =====
// ============================================================================
// ppcb_datapath
// Limit registers, transaction capture, pre-checks, slot table memory with a
// one-compare-per-cycle scan, commit logic and the output register.
// ============================================================================
module ppcb_datapath
    import ppcb_pkg::*;
#(
    parameter int PEER_SLOTS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppcb_cmd_t             cmd,
    output ppcb_sts_t             sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  kind,
    input  logic [WORD_W-1:0]     peer_word0,
    input  logic [WORD_W-1:0]     peer_word1,
    input  logic [WORD_W-1:0]     peer_word2,
    input  logic [WORD_W-1:0]     peer_word3,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [SIZE_W-1:0]     response_size,
    input  logic [SIZE_W-1:0]     timeout_value,
    output logic [STATUS_W-1:0]   status,
    output logic [CNT_W-1:0]      active_count
);

    localparam int IDX_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int SCAN_W = $clog2(PEER_SLOTS + 1);
    localparam int OCC_W  = (SCAN_W > PEERS_W) ? SCAN_W : PEERS_W;
    localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(PEER_SLOTS);

    // limit registers
    logic [CNT_W-1:0]   lim_conc_reg;
    logic [PEERS_W-1:0] lim_peers_reg;
    logic [CNT_W-1:0]   lim_per_peer_reg;
    logic [SIZE_W-1:0]  lim_req_reg;
    logic [SIZE_W-1:0]  lim_resp_reg;
    logic [SIZE_W-1:0]  lim_tmo_reg;

    // captured transaction
    logic               kind_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  req_reg;
    logic [SIZE_W-1:0]  resp_reg;
    logic [SIZE_W-1:0]  tmo_reg;

    // slot table
    logic [KEY_W-1:0]      slot_key_reg   [PEER_SLOTS];
    logic [CNT_W-1:0]      slot_count_reg [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] slot_used_reg;
    logic [SCAN_W-1:0]     used_cnt_reg;
    logic [CNT_W-1:0]      active_total_reg;

    // scan pipeline
    logic [SCAN_W-1:0] iss_cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [KEY_W-1:0]  rd_key_reg;
    logic [CNT_W-1:0]  rd_cnt_reg;
    logic              rd_used_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;

    status_t           res_code_reg;
    status_t           status_reg;
    logic [CNT_W-1:0]  active_count_reg;

    logic              cfg_ok;
    status_t           pre_code;
    logic              issue;
    logic [IDX_W-1:0]  iss_idx;
    logic              key_match;

    status_t           res_code;
    logic              apply;
    logic [IDX_W-1:0]  widx;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              new_peer;
    logic              clr_used;
    logic              act_inc;

    // ------------------------------------------------------------------
    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_conc_reg     <= '0;
            lim_peers_reg    <= '0;
            lim_per_peer_reg <= '0;
            lim_req_reg      <= '0;
            lim_resp_reg     <= '0;
            lim_tmo_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LIMIT_CONCURRENT:     lim_conc_reg     <= cfg_data[CNT_W-1:0];
                CFG_LIMIT_PENDING_PEERS:  lim_peers_reg    <= cfg_data[PEERS_W-1:0];
                CFG_LIMIT_PER_PEER:       lim_per_peer_reg <= cfg_data[CNT_W-1:0];
                CFG_LIMIT_REQUEST_BYTES:  lim_req_reg      <= cfg_data[SIZE_W-1:0];
                CFG_LIMIT_RESPONSE_BYTES: lim_resp_reg     <= cfg_data[SIZE_W-1:0];
                CFG_LIMIT_TIMEOUT_MS:     lim_tmo_reg      <= cfg_data[SIZE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pre-checks, in priority order
    assign cfg_ok = (lim_conc_reg != '0) && (lim_peers_reg != '0)
                 && (lim_per_peer_reg != '0) && (lim_per_peer_reg <= lim_conc_reg)
                 && (lim_req_reg != '0) && (lim_resp_reg != '0) && (lim_tmo_reg != '0);

    always_comb
    begin
        pre_code = ST_OK;
        if (kind_reg == KIND_RELEASE)
            pre_code = ST_OK;
        else if (!cfg_ok || (key_reg == '0))
            pre_code = ST_BAD_CONFIG;
        else if (req_reg > lim_req_reg)
            pre_code = ST_REQUEST_BIG;
        else if (resp_reg > lim_resp_reg)
            pre_code = ST_RESPONSE_BIG;
        else if ((tmo_reg == '0) || (tmo_reg > lim_tmo_reg))
            pre_code = ST_TIMEOUT_BAD;
        else if (active_total_reg >= lim_conc_reg)
            pre_code = ST_CONCURRENCY;
    end

    assign sts.pre_fail = (pre_code != ST_OK);

    // ------------------------------------------------------------------
    // slot scan: one read issued and one key compared per cycle
    assign issue     = cmd.scan_run && (iss_cnt_reg != SCAN_END) && !hit_reg;
    assign iss_idx   = iss_cnt_reg[IDX_W-1:0];
    assign key_match = rd_used_reg && (rd_key_reg == key_reg);

    assign sts.scan_done = hit_reg || ((iss_cnt_reg == SCAN_END) && !cmp_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_cnt_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            iss_cnt_reg    <= '0;
            cmp_vld_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= issue;
            if (issue)
                iss_cnt_reg <= iss_cnt_reg + SCAN_W'(1);
            if (cmp_vld_reg && !hit_reg)
            begin
                if (key_match)
                    hit_reg <= 1'b1;
                else if (!rd_used_reg)
                    free_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            cmp_idx_reg <= iss_idx;
        if (cmp_vld_reg && !hit_reg)
        begin
            if (key_match)
            begin
                hit_idx_reg <= cmp_idx_reg;
                hit_cnt_reg <= rd_cnt_reg;
            end
            else if (!rd_used_reg && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // decision from the scan result
    always_comb
    begin
        res_code  = ST_OK;
        widx      = hit_idx_reg;
        cnt_wdata = hit_cnt_reg + CNT_W'(1);
        new_peer  = 1'b0;
        clr_used  = 1'b0;
        act_inc   = 1'b1;
        if (kind_reg == KIND_RELEASE)
        begin
            act_inc   = 1'b0;
            cnt_wdata = hit_cnt_reg - CNT_W'(1);
            if (!hit_reg || (hit_cnt_reg == '0))
                res_code = ST_NOT_HELD;
            else
                clr_used = (hit_cnt_reg == CNT_W'(1));
        end
        else if (hit_reg)
        begin
            if (hit_cnt_reg >= lim_per_peer_reg)
                res_code = ST_PEER_LIMIT;
        end
        else
        begin
            widx      = free_idx_reg;
            cnt_wdata = CNT_W'(1);
            new_peer  = 1'b1;
            if ((OCC_W'(used_cnt_reg) >= OCC_W'(lim_peers_reg)) || !free_found_reg)
                res_code = ST_PEER_LIMIT;
        end
    end

    assign apply = cmd.commit && (res_code == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_used_reg    <= '0;
            used_cnt_reg     <= '0;
            active_total_reg <= '0;
        end
        else if (apply)
        begin
            if (act_inc)
                active_total_reg <= active_total_reg + CNT_W'(1);
            else
                active_total_reg <= active_total_reg - CNT_W'(1);
            if (new_peer)
            begin
                slot_used_reg[widx] <= 1'b1;
                used_cnt_reg        <= used_cnt_reg + SCAN_W'(1);
            end
            else if (clr_used)
            begin
                slot_used_reg[widx] <= 1'b0;
                used_cnt_reg        <= used_cnt_reg - SCAN_W'(1);
            end
        end
    end

    // slot memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (apply && new_peer)
            slot_key_reg[widx] <= key_reg;
        if (apply)
            slot_count_reg[widx] <= cnt_wdata;
        if (issue)
        begin
            rd_key_reg  <= slot_key_reg[iss_idx];
            rd_cnt_reg  <= slot_count_reg[iss_idx];
            rd_used_reg <= slot_used_reg[iss_idx];
        end
    end

    // ------------------------------------------------------------------
    // capture, result code, output register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= {peer_word3, peer_word2, peer_word1, peer_word0};
            req_reg  <= request_size;
            resp_reg <= response_size;
            tmo_reg  <= timeout_value;
        end
        if (cmd.check)
            res_code_reg <= pre_code;
        else if (cmd.commit)
            res_code_reg <= res_code;
        if (cmd.out_load)
        begin
            status_reg       <= res_code_reg;
            active_count_reg <= active_total_reg;
        end
    end

    assign status       = status_reg;
    assign active_count = active_count_reg;

endmodule

// ===== rtl/per_peer_concurrency_budget_unit.sv =====
// Flow: an acquire rejected by its limit checks goes from capture through the
//   check step to the finish step; otherwise the slot scan and commit follow.
// Throughput: one transaction at a time; a new one is taken once the last has
//   left the finish step, and the slot scan covers one slot per cycle.
// Reset: rst_n clears the limits, the slot used bits and the active total;
//   the block is ready as soon as reset is released, with no clearing pass.
// ============================================================================
// per_peer_concurrency_budget_unit
// Admission budget for probes: limit checks, then a per-peer slot table that
// tracks active probes per 256-bit peer key, with a global active total.
// ============================================================================
module per_peer_concurrency_budget_unit
    import ppcb_pkg::*;
#(
    parameter int PEER_SLOTS = 16     // slot table depth, 1 to 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // limit register write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // request transactions
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [WORD_W-1:0]     peer_word0,
    input  logic [WORD_W-1:0]     peer_word1,
    input  logic [WORD_W-1:0]     peer_word2,
    input  logic [WORD_W-1:0]     peer_word3,
    input  logic [SIZE_W-1:0]     request_size,
    input  logic [SIZE_W-1:0]     response_size,
    input  logic [SIZE_W-1:0]     timeout_value,

    // result transactions
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [CNT_W-1:0]      active_count
);

    // The controller walks each transaction through:
    //   capture -> limit checks -> slot scan -> commit -> output register.
    // Acquire checks (first failure wins): config/key, request size,
    // response size, timeout, global active limit, then the slot table.
    // Release skips the limit checks and goes straight to the scan.
    //
    // The scan is a two-stage pipe: a read of slot i is issued while slot i-1
    // is compared against the captured key. It stops on the first key hit;
    // on a miss it runs over every slot and remembers the lowest free one.
    //
    // The output register lets a new request be taken while the previous
    // result is still waiting on out_ready; the new result is held back in
    // the finish step until the register frees up.

    ppcb_cmd_t cmd;
    ppcb_sts_t sts;

    ppcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    ppcb_datapath #(
        .PEER_SLOTS (PEER_SLOTS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .peer_word0    (peer_word0),
        .peer_word1    (peer_word1),
        .peer_word2    (peer_word2),
        .peer_word3    (peer_word3),
        .request_size  (request_size),
        .response_size (response_size),
        .timeout_value (timeout_value),
        .status        (status),
        .active_count  (active_count)
    );

endmodule

// ===== rtl/ppcb_checker.sv =====
// ============================================================================
// ppcb_checker
// Port-level checks for the per-peer concurrency budget unit.
// ============================================================================
module ppcb_checker
    import ppcb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] status,
    input logic [CNT_W-1:0]    active_count
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(active_count))
        else $error("result changed while stalled");

    // one transaction in flight: ready drops right after acceptance
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while busy");

    // a new result only comes out of the finish step, never from idle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");

endmodule

bind per_peer_concurrency_budget_unit ppcb_checker u_ppcb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .active_count (active_count)
);
